### hdl/prim_mst_pkg.sv
package prim_mst_pkg;

    // fixed field widths
    localparam int WEIGHT_W     = 16;
    localparam int NODE_COUNT_W = 6;

    // default sizing
    localparam int DEFAULT_MAX_NODES   = 32;
    localparam int DEFAULT_WEIGHT_BITS = 16;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_write;  // store one matrix entry
        logic cfg_write;   // take a new node count
        logic run_start;   // begin a tree run from node 0
        logic scan_step;   // advance the edge scan
        logic commit;      // add the best edge and rescan
        logic finish;      // emit the final transaction
    } prim_mst_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic load_last;   // load pointer sits on the last matrix entry
        logic scan_done;   // every row has been walked
        logic found;       // the scan found a crossing edge
        logic pend_valid;  // an edge waits to be emitted
        logic out_free;    // output register can take a transaction
    } prim_mst_stat_t;

endpackage

### hdl/prim_mst_if.sv
// configuration write channel
interface prim_mst_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [prim_mst_pkg::NODE_COUNT_W-1:0] node_count;

    modport source (output valid, output node_count, input ready);
    modport sink   (input valid, input node_count, output ready);
endinterface

// matrix entry channel
interface prim_mst_weight_if;
    logic                          valid;
    logic                          ready;
    logic [prim_mst_pkg::WEIGHT_W-1:0] weight;

    modport source (output valid, output weight, input ready);
    modport sink   (input valid, input weight, output ready);
endinterface

// tree edge result channel
interface prim_mst_result_if #(
    parameter int NODE_BITS = 5
);
    logic                          valid;
    logic                          ready;
    logic                          edge_valid;
    logic [NODE_BITS-1:0]          from_node;
    logic [NODE_BITS-1:0]          to_node;
    logic [prim_mst_pkg::WEIGHT_W-1:0] edge_weight;
    logic                          last_edge;

    modport source (output valid, output edge_valid, output from_node, output to_node,
                    output edge_weight, output last_edge, input ready);
    modport sink   (input valid, input edge_valid, input from_node, input to_node,
                    input edge_weight, input last_edge, output ready);
endinterface

### hdl/prim_mst_ctrl.sv
module prim_mst_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  prim_mst_pkg::prim_mst_stat_t stat,
    output prim_mst_pkg::prim_mst_cmd_t  cmd
);
    import prim_mst_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_START  = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_write = in_valid;
                cmd.cfg_write  = cfg_valid;
                if (in_valid && stat.load_last)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.run_start = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = !stat.scan_done;
                if (stat.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.found)
                begin
                    // a held edge must reach the output register first
                    if (!stat.pend_valid || stat.out_free)
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_SCAN;
                    end
                end
                else if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/prim_mst_dp.sv
module prim_mst_dp #(
    parameter int MAX_NODES   = prim_mst_pkg::DEFAULT_MAX_NODES,
    parameter int WEIGHT_BITS = prim_mst_pkg::DEFAULT_WEIGHT_BITS,
    parameter int NODE_BITS   = $clog2(MAX_NODES)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  prim_mst_pkg::prim_mst_cmd_t           cmd,
    output prim_mst_pkg::prim_mst_stat_t          stat,
    input  logic [prim_mst_pkg::WEIGHT_W-1:0]     weight_in,
    input  logic [prim_mst_pkg::NODE_COUNT_W-1:0] cfg_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  out_edge_valid,
    output logic [NODE_BITS-1:0]                  out_from,
    output logic [NODE_BITS-1:0]                  out_to,
    output logic [prim_mst_pkg::WEIGHT_W-1:0]     out_weight,
    output logic                                  out_last
);
    import prim_mst_pkg::*;

    localparam int CNT_BITS  = $clog2(MAX_NODES + 1);
    localparam int ADDR_BITS = 2 * NODE_BITS;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    // weight memory, addressed by {row, col}
    logic [WEIGHT_BITS-1:0] mem [MEM_DEPTH];
    logic [WEIGHT_BITS-1:0] rd_data_reg;

    logic [CNT_BITS-1:0]  act_n_reg;
    logic [CNT_BITS-1:0]  act_n_next;
    logic [NODE_BITS-1:0] last_idx;

    logic [NODE_BITS-1:0] ld_row_reg, ld_row_next;
    logic [NODE_BITS-1:0] ld_col_reg, ld_col_next;

    logic [NODE_BITS-1:0] sc_i_reg, sc_i_next;
    logic [NODE_BITS-1:0] sc_j_reg, sc_j_next;
    logic                 sc_done_reg, sc_done_next;
    logic                 rd_en;

    logic                 p_valid_reg;
    logic [NODE_BITS-1:0] p_i_reg;
    logic [NODE_BITS-1:0] p_j_reg;

    logic [MAX_NODES-1:0] visited_reg, visited_next;
    logic                 found_reg, found_next;
    logic                 cand;
    logic [WEIGHT_BITS-1:0] best_w_reg;
    logic [NODE_BITS-1:0]   best_i_reg;
    logic [NODE_BITS-1:0]   best_j_reg;

    logic                   pend_valid_reg, pend_valid_next;
    logic [WEIGHT_BITS-1:0] pend_w_reg;
    logic [NODE_BITS-1:0]   pend_i_reg;
    logic [NODE_BITS-1:0]   pend_j_reg;

    logic out_valid_reg, out_valid_next;
    logic push;

    // clamp the written node count into 1..MAX_NODES
    always_comb
    begin
        act_n_next = act_n_reg;
        if (cmd.cfg_write)
        begin
            if (cfg_data == '0)
            begin
                act_n_next = CNT_BITS'(1);
            end
            else if (32'(cfg_data) > MAX_NODES)
            begin
                act_n_next = CNT_BITS'(MAX_NODES);
            end
            else
            begin
                act_n_next = CNT_BITS'(cfg_data);
            end
        end
    end

    assign last_idx = NODE_BITS'(act_n_reg - CNT_BITS'(1));

    // load pointer walks row-major over the active square
    always_comb
    begin
        ld_row_next = ld_row_reg;
        ld_col_next = ld_col_reg;
        if (cmd.cfg_write)
        begin
            ld_row_next = '0;
            ld_col_next = '0;
        end
        else if (cmd.load_write)
        begin
            if (ld_col_reg == last_idx)
            begin
                ld_col_next = '0;
                ld_row_next = (ld_row_reg == last_idx) ? '0 : ld_row_reg + 1'b1;
            end
            else
            begin
                ld_col_next = ld_col_reg + 1'b1;
            end
        end
    end

    // scan walker, unvisited rows are skipped without a memory read
    always_comb
    begin
        sc_i_next    = sc_i_reg;
        sc_j_next    = sc_j_reg;
        sc_done_next = sc_done_reg;
        rd_en        = 1'b0;
        if (cmd.run_start || cmd.commit)
        begin
            sc_i_next    = '0;
            sc_j_next    = '0;
            sc_done_next = 1'b0;
        end
        else if (cmd.scan_step && !sc_done_reg)
        begin
            rd_en = visited_reg[sc_i_reg];
            if (!visited_reg[sc_i_reg] || sc_j_reg == last_idx)
            begin
                sc_j_next = '0;
                if (sc_i_reg == last_idx)
                begin
                    sc_done_next = 1'b1;
                end
                else
                begin
                    sc_i_next = sc_i_reg + 1'b1;
                end
            end
            else
            begin
                sc_j_next = sc_j_reg + 1'b1;
            end
        end
    end

    // compare stage: strict less keeps the first pair in scan order
    assign cand = p_valid_reg && !visited_reg[p_j_reg] && (rd_data_reg != '0)
                  && (!found_reg || rd_data_reg < best_w_reg);

    always_comb
    begin
        found_next = found_reg;
        if (cmd.run_start || cmd.commit)
        begin
            found_next = 1'b0;
        end
        else if (cand)
        begin
            found_next = 1'b1;
        end
    end

    // visited set and held edge
    always_comb
    begin
        visited_next    = visited_reg;
        pend_valid_next = pend_valid_reg;
        if (cmd.run_start)
        begin
            visited_next    = {{(MAX_NODES-1){1'b0}}, 1'b1};
            pend_valid_next = 1'b0;
        end
        else if (cmd.commit)
        begin
            visited_next    = visited_reg | ({{(MAX_NODES-1){1'b0}}, 1'b1} << best_j_reg);
            pend_valid_next = 1'b1;
        end
        else if (cmd.finish)
        begin
            pend_valid_next = 1'b0;
        end
    end

    // output register
    assign push = (cmd.commit && pend_valid_reg) || cmd.finish;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_n_reg      <= CNT_BITS'(1);
            ld_row_reg     <= '0;
            ld_col_reg     <= '0;
            sc_i_reg       <= '0;
            sc_j_reg       <= '0;
            sc_done_reg    <= 1'b0;
            p_valid_reg    <= 1'b0;
            visited_reg    <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            act_n_reg      <= act_n_next;
            ld_row_reg     <= ld_row_next;
            ld_col_reg     <= ld_col_next;
            sc_i_reg       <= sc_i_next;
            sc_j_reg       <= sc_j_next;
            sc_done_reg    <= sc_done_next;
            p_valid_reg    <= rd_en;
            visited_reg    <= visited_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load_write)
        begin
            mem[{ld_row_reg, ld_col_reg}] <= weight_in[WEIGHT_BITS-1:0];
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[{sc_i_reg, sc_j_reg}];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        p_i_reg <= sc_i_reg;
        p_j_reg <= sc_j_reg;
        if (cand)
        begin
            best_w_reg <= rd_data_reg;
            best_i_reg <= p_i_reg;
            best_j_reg <= p_j_reg;
        end
        if (cmd.commit)
        begin
            pend_w_reg <= best_w_reg;
            pend_i_reg <= best_i_reg;
            pend_j_reg <= best_j_reg;
        end
        if (push)
        begin
            out_edge_valid <= pend_valid_reg;
            out_from       <= pend_valid_reg ? pend_i_reg : '0;
            out_to         <= pend_valid_reg ? pend_j_reg : '0;
            out_weight     <= pend_valid_reg ? WEIGHT_W'(pend_w_reg) : '0;
            out_last       <= cmd.finish;
        end
    end

    assign out_valid = out_valid_reg;

    // status back to the controller
    assign stat.load_last  = (ld_row_reg == last_idx) && (ld_col_reg == last_idx);
    assign stat.scan_done  = sc_done_reg;
    assign stat.found      = found_reg;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

### hdl/prim_minimum_spanning_tree_top.sv
// channel   | direction | payload                                          | handshake
// cfg       | in        | node_count[5:0]                                  | valid/ready
// weights   | in        | weight[15:0], row-major matrix entries            | valid/ready
// results   | out       | edge_valid, from_node, to_node, edge_weight,      | valid/ready
//           |           | last_edge                                        |
//
// loading takes one cycle per matrix entry, written straight into the weight memory
// each tree round walks the rows: every entry of a visited row is read, an unvisited row
// is skipped without a memory read, and the controller then decides on the best edge
// the single-port read of the weight memory sets the scan pace
// no clearing pass after reset; node_count resets to 1 and the load pointer to zero
// a stalled results channel holds the run at the next edge; loading resumes once
// the final transaction sits in the output register
module prim_minimum_spanning_tree_top #(
    parameter int MAX_NODES   = prim_mst_pkg::DEFAULT_MAX_NODES,
    parameter int WEIGHT_BITS = prim_mst_pkg::DEFAULT_WEIGHT_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    prim_mst_cfg_if.sink             cfg,
    prim_mst_weight_if.sink          weights,
    prim_mst_result_if.source        results
);
    import prim_mst_pkg::*;

    localparam int NODE_BITS = $clog2(MAX_NODES);

    prim_mst_cmd_t  cmd;
    prim_mst_stat_t stat;

    // sequencing
    prim_mst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (weights.valid),
        .in_ready  (weights.ready),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // storage, scan and output register
    prim_mst_dp #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS),
        .NODE_BITS   (NODE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .weight_in      (weights.weight),
        .cfg_data       (cfg.node_count),
        .out_valid      (results.valid),
        .out_ready      (results.ready),
        .out_edge_valid (results.edge_valid),
        .out_from       (results.from_node),
        .out_to         (results.to_node),
        .out_weight     (results.edge_weight),
        .out_last       (results.last_edge)
    );

endmodule

### hdl/prim_mst_checker.sv
module prim_mst_checker #(
    parameter int NODE_BITS = 5
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cfg_ready,
    input logic                              weights_ready,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic                              res_edge_valid,
    input logic [NODE_BITS-1:0]              res_from,
    input logic [NODE_BITS-1:0]              res_to,
    input logic [prim_mst_pkg::WEIGHT_W-1:0] res_weight,
    input logic                              res_last
);
    import prim_mst_pkg::*;

    // a stalled transaction stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // the empty transaction is all zero and closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_edge_valid |-> res_last && res_from == '0 && res_to == '0
        && res_weight == '0)
        else $error("malformed empty result");

    // a tree edge has a real weight and joins two distinct nodes
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_edge_valid |-> res_weight != '0 && res_from != res_to)
        else $error("bad tree edge");

    // loading and configuration open and close together
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready == weights_ready)
        else $error("cfg and weight ready disagree");

endmodule

bind prim_minimum_spanning_tree_top prim_mst_checker #(
    .NODE_BITS ($clog2(MAX_NODES))
) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_ready      (cfg.ready),
    .weights_ready  (weights.ready),
    .res_valid      (results.valid),
    .res_ready      (results.ready),
    .res_edge_valid (results.edge_valid),
    .res_from       (results.from_node),
    .res_to         (results.to_node),
    .res_weight     (results.edge_weight),
    .res_last       (results.last_edge)
);
